// File: rtl/core/mtg_pkg.sv
// Shared constants, command/status types and word functions for the MT19937 generator.
`default_nettype none

package mtg_pkg;

   localparam int unsigned N_WORDS   = 624;
   localparam int unsigned M_OFFSET  = 397;
   localparam int unsigned ADDR_W    = 10;

   localparam logic [ADDR_W-1:0] POS_FULL     = ADDR_W'(N_WORDS);
   localparam logic [ADDR_W-1:0] POS_UNSEEDED = ADDR_W'(N_WORDS + 1);
   localparam logic [ADDR_W-1:0] LAST_INDEX   = ADDR_W'(N_WORDS - 1);
   // far tap of element k-1 is issued at step k, so offset is M-1
   localparam logic [ADDR_W:0]   FAR_ISSUE_OFS = (ADDR_W+1)'(M_OFFSET - 1);
   localparam logic [ADDR_W:0]   N_WIDE        = (ADDR_W+1)'(N_WORDS);

   localparam logic [31:0] DEFAULT_SEED = 32'd5489;
   localparam logic [31:0] INIT_MULT    = 32'd1812433253;
   localparam logic [31:0] MATRIX_A     = 32'h9908_b0df;
   localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
   localparam logic [31:0] LOWER_MASK   = 32'h7fff_ffff;
   localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

   localparam logic OP_SEED = 1'b0;
   localparam logic OP_NEXT = 1'b1;

   typedef struct packed {
      logic              mem_we;
      logic              wsel_twist;
      logic [ADDR_W-1:0] waddr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      logic              seed_load;
      logic              seed_default;
      logic              seed_step;
      logic              out_load;
   } mtg_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } mtg_status_type;

   function automatic logic [31:0] mtg_seed_next(input logic [31:0] prev,
                                                 input logic [ADDR_W-1:0] idx);
      logic [31:0] p;
      p = prev ^ (prev >> 30);
      return 32'(p * INIT_MULT) + {{(32-ADDR_W){1'b0}}, idx};
   endfunction

   function automatic logic [31:0] mtg_mix(input logic [31:0] hi_src,
                                           input logic [31:0] lo_src,
                                           input logic [31:0] far);
      logic [31:0] y;
      y = (hi_src & UPPER_MASK) | (lo_src & LOWER_MASK);
      return far ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
   endfunction

   function automatic logic [31:0] mtg_temper(input logic [31:0] w);
      logic [31:0] y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/mersenne_twister_generator.sv
// Top level of the MT19937 32-bit pseudo-random word generator.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_ready  | req_op, req_seed_value[31:0]
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_random_word[31:0]
//
// Steps: a next request is accepted, reads the table, then is tempered into
// the result register. Every 624th word first runs a twist pass, one element
// per cycle through the two read ports of the table.
// A seed request writes one table entry per cycle through the
// seed multiplier and makes no transfer on rsp.
// After reset the table is unseeded; the first next request seeds with 5489,
// twists, then delivers. The table itself is not cleared.
// A stalled rsp holds the result register; a new request is still taken and
// waits at its final step until the register frees.
`default_nettype none

module mersenne_twister_generator
   import mtg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [31:0] req_seed_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_random_word
);

   mtg_cmd_type    cmd;
   mtg_status_type status;

   // sequencer: owns read position and pass counter
   mtg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .cmd       (cmd),
      .status    (status)
   );

   // table memory, arithmetic and result register
   mtg_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_seed_value  (req_seed_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_random_word (rsp_random_word)
   );

endmodule

`default_nettype wire

// File: rtl/core/mtg_datapath.sv
// Datapath: state table memory, seed recurrence, twist mixer, tempering and result register.
`default_nettype none

module mtg_datapath
   import mtg_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [31:0]    req_seed_value,
   input  wire mtg_cmd_type    cmd,
   output mtg_status_type      status,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic [31:0]         rsp_random_word
);

   logic [31:0] table_mem [0:N_WORDS-1];

   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;
   logic [31:0] cur_ff;
   logic [31:0] word_ff, word_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] wdata;

   // two reads, one write per cycle; read data registered
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         table_mem[cmd.waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= table_mem[cmd.rd_addr_a];
         rd_b_ff <= table_mem[cmd.rd_addr_b];
         cur_ff  <= rd_a_ff;
      end
   end

   always_comb begin
      wdata = cmd.wsel_twist ? mtg_mix(cur_ff, rd_a_ff, rd_b_ff) : word_ff;

      word_in = word_ff;
      if (cmd.seed_load) begin
         word_in = cmd.seed_default ? DEFAULT_SEED : req_seed_value;
      end else if (cmd.seed_step) begin
         word_in = mtg_seed_next(word_ff, cmd.waddr + ADDR_W'(1));
      end

      rsp_word_in  = cmd.out_load ? mtg_temper(rd_a_ff) : rsp_word_ff;
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.out_blocked = rsp_valid_ff && !rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_random_word    = rsp_word_ff;

endmodule

`default_nettype wire

// File: rtl/core/mtg_ctrl.sv
// Controller: sequences seeding, twisting and word fetch, and tracks the read position.
`default_nettype none

module mtg_ctrl
   import mtg_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic           req_op,
   output mtg_cmd_type         cmd,
   input  wire mtg_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_TWIST,
      ST_FETCH,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W:0]   far_sum;
   logic [ADDR_W:0]   far_wrap;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      pend_in   = pend_ff;
      cmd       = '0;
      req_ready = 1'b0;
      far_sum   = {1'b0, cnt_ff} + FAR_ISSUE_OFS;
      far_wrap  = (far_sum >= N_WIDE) ? far_sum - N_WIDE : far_sum;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cnt_in = '0;
               if (req_op == OP_SEED) begin
                  cmd.seed_load = 1'b1;
                  pend_in       = 1'b0;
                  state_in      = ST_SEED;
               end else if (pos_ff == POS_UNSEEDED) begin
                  cmd.seed_load    = 1'b1;
                  cmd.seed_default = 1'b1;
                  pend_in          = 1'b1;
                  state_in         = ST_SEED;
               end else if (pos_ff >= POS_FULL) begin
                  state_in = ST_TWIST;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_SEED: begin
            cmd.mem_we    = 1'b1;
            cmd.waddr     = cnt_ff;
            cmd.seed_step = 1'b1;
            cnt_in        = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_INDEX) begin
               cnt_in   = '0;
               pos_in   = POS_FULL;
               pend_in  = 1'b0;
               state_in = pend_ff ? ST_TWIST : ST_IDLE;
            end
         end
         ST_TWIST: begin
            // step k reads t[k] and far tap of element k-1, writes element k-2
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = (cnt_ff >= POS_FULL) ? '0 : cnt_ff;
            cmd.rd_addr_b = far_wrap[ADDR_W-1:0];
            if (cnt_ff >= ADDR_W'(2)) begin
               cmd.mem_we     = 1'b1;
               cmd.wsel_twist = 1'b1;
               cmd.waddr      = cnt_ff - ADDR_W'(2);
            end
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == POS_UNSEEDED) begin
               cnt_in   = '0;
               pos_in   = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = pos_ff;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.out_blocked) begin
               cmd.out_load = 1'b1;
               pos_in       = pos_ff + ADDR_W'(1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= POS_UNSEEDED;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/mtg_checker.sv
// Port-level checker for the MT19937 generator, bound to the top level.
`default_nettype none

module mtg_checker
   import mtg_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_op,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_random_word
);

   // result waits intact while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_word))
      else $error("rsp payload changed while stalled");

   // a seed transfer never produces a result
   a_seed_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_SEED |=> !$rose(rsp_valid))
      else $error("result raised after seed transfer");

   // one request at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the MT19937 word generator: random traffic scored against a local model.
`default_nettype none

module tb
   import mtg_pkg::*;
();

   // Longest correct quiet stretch: first next after reset (seed + twist) or
   // seed followed by next, plus a receiver stall, or the deliberate receiver
   // hold-off. Several times that is plenty.
   localparam int unsigned IDLE_LIMIT   = 5000;
   localparam int unsigned HOLD_CYCLES  = 300;
   // A trailing seed makes no rsp transfer but keeps the block busy.
   localparam int unsigned DRAIN_CYCLES = 1300;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_op         = OP_NEXT;
   logic [31:0] req_seed_value = '0;
   logic        rsp_ready      = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [31:0] rsp_random_word;

   // Local copy of the generator state, advanced on every accepted request.
   logic [31:0]       mt_tbl [N_WORDS];
   logic [ADDR_W-1:0] mt_pos = POS_UNSEEDED;

   logic [31:0] expected_words [$];
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;

   bit req_burst     = 1'b0;  // sender: back-to-back stretch
   bit rsp_burst     = 1'b0;  // receiver: always-ready stretch
   bit rsp_hold_req  = 1'b0;  // receiver: one long hold-off requested

   always #5 clock = ~clock;

   mersenne_twister_generator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_seed_value  (req_seed_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_random_word (rsp_random_word)
   );

   // ---------------------------------------------------------------------
   // Generator model
   // ---------------------------------------------------------------------

   // Seed fill: t[0] = seed, t[i] = mult * (t[i-1] ^ t[i-1] >> 30) + i.
   function automatic void mt_seed_fill(input logic [31:0] seed);
      logic [31:0] prev;
      logic [31:0] idx;
      mt_tbl[0] = seed;
      for (int unsigned i = 1; i < N_WORDS; i++) begin
         prev      = mt_tbl[i-1];
         idx       = i;
         mt_tbl[i] = 32'((prev ^ (prev >> 30)) * INIT_MULT) + idx;
      end
      mt_pos = POS_FULL;
   endfunction

   // In-place twist; later elements see the already updated low entries.
   function automatic void mt_twist_all();
      logic [31:0] y;
      for (int unsigned i = 0; i < N_WORDS; i++) begin
         y = (mt_tbl[i] & UPPER_MASK) | (mt_tbl[(i + 1) % N_WORDS] & LOWER_MASK);
         mt_tbl[i] = mt_tbl[(i + M_OFFSET) % N_WORDS] ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
      end
      mt_pos = '0;
   endfunction

   function automatic logic [31:0] mt_temper_word(input logic [31:0] w);
      logic [31:0] y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // Next word: unseeded table self-seeds with the default, used-up table twists.
   function automatic logic [31:0] mt_next_word();
      logic [31:0] w;
      if (mt_pos >= POS_FULL) begin
         if (mt_pos == POS_UNSEEDED) mt_seed_fill(DEFAULT_SEED);
         mt_twist_all();
      end
      w      = mt_tbl[mt_pos % N_WORDS];
      mt_pos = mt_pos + 1'b1;
      return mt_temper_word(w);
   endfunction

   // ---------------------------------------------------------------------
   // Scoring
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %08h want %08h", what, got, want);
      mismatch_count++;
   endtask

   // Checks the rsp transfer first; a transfer on rsp always belongs to a
   // request taken at an earlier edge, so the order of the two is free.
   always @(posedge clock) begin : scoreboard
      logic [31:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("random_word with nothing outstanding", rsp_random_word, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_random_word !== want)
                  report_mismatch("random_word", rsp_random_word, want);
            end
         end
         if (req_valid && req_ready) begin
            if (req_op == OP_SEED) mt_seed_fill(req_seed_value);
            else expected_words = {expected_words, mt_next_word()};
         end
      end
   end

   // Watchdog: ends the run when no transfer happens on either channel too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls per result, ready stretches, one long hold-off
   // ---------------------------------------------------------------------
   initial begin : receiver
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end
         if ($urandom_range(0, 24) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 16);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------

   // Offers one request after a random gap; valid stays up after the
   // transfer so a zero gap gives back-to-back requests.
   task automatic send_request(input logic op, input logic [31:0] seed);
      int unsigned gap;
      if ($urandom_range(0, 29) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_seed_value <= seed;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, then wait until every outstanding word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // Next before any seed: default seed, twist, then words.
   task automatic test_unseeded_next();
      repeat (3) send_request(OP_NEXT, $urandom());
   endtask

   // Seed extremes, default seed given explicitly, back-to-back seeds.
   task automatic test_seed_extremes();
      send_request(OP_SEED, 32'h0000_0000);
      repeat (2) send_request(OP_NEXT, $urandom());
      send_request(OP_SEED, 32'hffff_ffff);
      repeat (2) send_request(OP_NEXT, $urandom());
      send_request(OP_SEED, DEFAULT_SEED);
      send_request(OP_NEXT, $urandom());
      send_request(OP_SEED, 32'h8000_0000);
      send_request(OP_SEED, 32'h7fff_ffff);
      send_request(OP_NEXT, $urandom());
   endtask

   // Reseed mid-stream with the same value restarts the sequence.
   task automatic test_reseed_drops();
      send_request(OP_SEED, 32'h1234_5678);
      repeat (3) send_request(OP_NEXT, $urandom());
      send_request(OP_SEED, 32'h1234_5678);
      repeat (2) send_request(OP_NEXT, $urandom());
   endtask

   // Receiver holds off while the sender keeps going, so the block backs up
   // and drops req_ready; then the sender waits for a full drain.
   task automatic test_backpressure();
      wait_drained();
      rsp_hold_req = 1'b1;
      repeat (16) send_request(OP_NEXT, $urandom());
      wait_drained();
   endtask

   // Long run without seeds: crosses the 624-word boundary into a plain twist.
   task automatic test_long_run(input int unsigned count);
      repeat (count) send_request(OP_NEXT, $urandom());
   endtask

   // Mostly next requests, occasional reseed with a random value, and now
   // and then a full drain before continuing.
   task automatic test_random_mix(input int unsigned count);
      repeat (count) begin
         if ($urandom_range(0, 39) == 0) send_request(OP_SEED, $urandom());
         else send_request(OP_NEXT, $urandom());
         if ($urandom_range(0, 99) == 0) wait_drained();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unseeded_next();
      test_seed_extremes();
      test_reseed_drops();
      test_backpressure();
      test_long_run(700);
      test_random_mix(700);

      // Quiet tail covers a trailing seed still being written into the table.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: mersenne_twister_generator.f
rtl/core/mtg_pkg.sv
rtl/core/mtg_datapath.sv
rtl/core/mtg_ctrl.sv
rtl/core/mersenne_twister_generator.sv
rtl/core/mtg_checker.sv
tb/sv/tb.sv
